@@ rtl/core/rrst_pkg.sv @@
// Shared constants and types for the receive sequence tracker.
`default_nettype none
package rrst_pkg;

    // Width of the sequence number field on the input and ack ports.
    localparam int SEQ_IN_W      = 16;
    // Low bits of the sequence number that take part in tracking.
    localparam int SEQ_BITS      = 16;
    localparam int HALF_WINDOW   = 32768;
    // Marks per map word; a power of two.
    localparam int MAP_WORD_BITS = 32;
    localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
    localparam int MAP_DEPTH     = (2 ** SEQ_BITS) / MAP_WORD_BITS;
    localparam int MAP_ADDR_W    = SEQ_BITS - BIT_IDX_W;

    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;

    // Controls for one read-modify-write of a map word.
    typedef struct packed {
        logic                 is_new;   // number lies ahead of the newest
        logic                 first;    // word holds the first gap number
        logic                 last;     // word holds the received number
        logic [BIT_IDX_W-1:0] lo_bit;   // bit of the first gap number
        logic [BIT_IDX_W-1:0] seq_bit;  // bit of the received number
    } upd_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/rrst_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module rrst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/rrst_word_upd.sv @@
// Modify step for one missing-map word: sets gap marks and clears the received mark.
`default_nettype none
module rrst_word_upd
    import rrst_pkg::*;
(
    input  wire upd_ctrl_t                ctrl,
    input  wire logic [MAP_WORD_BITS-1:0] old_word,
    output logic      [MAP_WORD_BITS-1:0] new_word,
    output logic                          marked
);

    logic [BIT_IDX_W:0]     lo_eff;
    logic [BIT_IDX_W:0]     hi_eff;
    logic [MAP_WORD_BITS-1:0] set_mask;
    logic [MAP_WORD_BITS-1:0] seq_mask;

    // Gap numbers in this word run from lo_eff up to, not including, hi_eff.
    assign lo_eff = ctrl.first ? {1'b0, ctrl.lo_bit} : '0;
    assign hi_eff = ctrl.last ? {1'b0, ctrl.seq_bit} : (BIT_IDX_W + 1)'(MAP_WORD_BITS);

    always_comb begin
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            set_mask[i] = ctrl.is_new
                && ((BIT_IDX_W + 1)'(i) >= lo_eff)
                && ((BIT_IDX_W + 1)'(i) < hi_eff);
            seq_mask[i] = ctrl.last && (ctrl.seq_bit == BIT_IDX_W'(i));
        end
    end

    assign marked   = |(old_word & seq_mask);
    assign new_word = (old_word | set_mask) & ~seq_mask;

endmodule
`default_nettype wire

@@ rtl/core/reliable_receive_sequence_tracker.sv @@
// Top level of the receive sequence tracker: control sequencer, map RAM and output register.
//
// Usage: each word on the s_ channel carries one received sequence number in
// s_tdata. Each word taken yields exactly one word on the m_ channel holding
// the same number to acknowledge, a deliver flag and a filled_gap flag.
// Per item, one missing-map word is read, modified and written back, so an
// in-order or old number touches one word; the result is registered as the
// last word is written, and no new item is taken until then. A number that
// jumps ahead marks the skipped numbers missing one map word per cycle. The
// map RAM port pair allows this: one word read and one word written each cycle.
// After reset the map is cleared in one pass over all 2048 words, one word a
// cycle, during which s_tready stays low.
// The result sits in an output register, so the next word is accepted while
// a result waits. If the receiver stalls, the finished result is held until
// m_tready rises and no further word is accepted meanwhile.
`default_nettype none
module reliable_receive_sequence_tracker
    import rrst_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata: [15:0] seq_id
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata: [15:0] ack_id, [16] deliver, [17] filled_gap, [23:18] zero
    output logic      [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RMW   = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [MAP_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [SEQ_BITS-1:0]   newest_reg, newest_next;
    logic                  got_any_reg, got_any_next;
    logic                  m_valid_reg, m_valid_next;

    logic [SEQ_IN_W-1:0]   raw_reg, raw_next;
    logic                  is_new_reg, is_new_next;
    logic                  first_reg, first_next;
    logic [MAP_ADDR_W-1:0] word_addr_reg, word_addr_next;
    logic [MAP_ADDR_W-1:0] end_word_reg, end_word_next;
    logic [BIT_IDX_W-1:0]  lo_bit_reg, lo_bit_next;
    logic                  deliver_reg, deliver_next;
    logic                  filled_reg, filled_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic [SEQ_BITS-1:0]      seq_in;
    logic [SEQ_BITS-1:0]      ahead;
    logic [SEQ_BITS-1:0]      next_n;
    logic                     in_is_new;
    logic                     accept;
    logic                     out_free;
    logic                     last_word;
    logic                     res_deliver;
    logic                     res_filled;

    logic                     ram_wr_en;
    logic [MAP_ADDR_W-1:0]    ram_wr_addr;
    logic [MAP_WORD_BITS-1:0] ram_wr_data;
    logic                     ram_rd_en;
    logic [MAP_ADDR_W-1:0]    ram_rd_addr;
    logic [MAP_WORD_BITS-1:0] ram_rd_data;

    upd_ctrl_t                upd_ctrl;
    logic [MAP_WORD_BITS-1:0] upd_word;
    logic                     upd_marked;

    rrst_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_DEPTH)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rrst_word_upd u_word_upd (
        .ctrl     (upd_ctrl),
        .old_word (ram_rd_data),
        .new_word (upd_word),
        .marked   (upd_marked)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Classification of the incoming number against the newest one.
    assign seq_in    = s_tdata[SEQ_BITS-1:0];
    assign ahead     = seq_in - newest_reg;
    assign next_n    = newest_reg + SEQ_BITS'(1);
    assign in_is_new = ((ahead != '0) && ({1'b0, ahead} <= (SEQ_BITS + 1)'(HALF_WINDOW)))
                       || !got_any_reg;

    // An old number touches only its own word.
    assign last_word = !is_new_reg || (word_addr_reg == end_word_reg);

    assign upd_ctrl.is_new  = is_new_reg;
    assign upd_ctrl.first   = first_reg;
    assign upd_ctrl.last    = last_word;
    assign upd_ctrl.lo_bit  = lo_bit_reg;
    assign upd_ctrl.seq_bit = raw_reg[BIT_IDX_W-1:0];

    assign res_deliver = is_new_reg || upd_marked;
    assign res_filled  = !is_new_reg && upd_marked;

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        newest_next    = newest_reg;
        got_any_next   = got_any_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        raw_next       = raw_reg;
        is_new_next    = is_new_reg;
        first_next     = first_reg;
        word_addr_next = word_addr_reg;
        end_word_next  = end_word_reg;
        lo_bit_next    = lo_bit_reg;
        deliver_next   = deliver_reg;
        filled_next    = filled_reg;
        m_data_next    = m_data_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = word_addr_reg;
        ram_wr_data    = upd_word;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = word_addr_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
                clr_addr_next = clr_addr_reg + MAP_ADDR_W'(1);
                if (clr_addr_reg == MAP_ADDR_W'(MAP_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    raw_next       = s_tdata[SEQ_IN_W-1:0];
                    is_new_next    = in_is_new;
                    first_next     = 1'b1;
                    lo_bit_next    = next_n[BIT_IDX_W-1:0];
                    end_word_next  = seq_in[SEQ_BITS-1:BIT_IDX_W];
                    word_addr_next = in_is_new ? next_n[SEQ_BITS-1:BIT_IDX_W]
                                               : seq_in[SEQ_BITS-1:BIT_IDX_W];
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = word_addr_next;
                    state_next     = ST_RMW;
                end
            end
            ST_RMW: begin
                ram_wr_en = 1'b1;
                if (!last_word) begin
                    // The next word differs from the one written now, so the
                    // read can overlap the write.
                    word_addr_next = word_addr_reg + MAP_ADDR_W'(1);
                    first_next     = 1'b0;
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = word_addr_next;
                end else begin
                    if (is_new_reg) begin
                        newest_next  = raw_reg[SEQ_BITS-1:0];
                        got_any_next = 1'b1;
                    end
                    deliver_next = res_deliver;
                    filled_next  = res_filled;
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {(M_TDATA_W - SEQ_IN_W - 2)'(0),
                                        res_filled, res_deliver, raw_reg};
                        state_next   = ST_IDLE;
                    end else begin
                        state_next   = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(M_TDATA_W - SEQ_IN_W - 2)'(0),
                                    filled_reg, deliver_reg, raw_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            newest_reg   <= '0;
            got_any_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            newest_reg   <= newest_next;
            got_any_reg  <= got_any_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg       <= raw_next;
        is_new_reg    <= is_new_next;
        first_reg     <= first_next;
        word_addr_reg <= word_addr_next;
        end_word_reg  <= end_word_next;
        lo_bit_reg    <= lo_bit_next;
        deliver_reg   <= deliver_next;
        filled_reg    <= filled_next;
        m_data_reg    <= m_data_next;
    end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the receive sequence tracker: directed, random and stall tests.
`default_nettype none
module tb;
    import rrst_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 100;
    localparam int PAD_W          = M_TDATA_W - SEQ_IN_W - 2;

    // Same layout as m_tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic [PAD_W-1:0]    pad;
        logic                filled_gap;
        logic                deliver;
        logic [SEQ_IN_W-1:0] ack_id;
    } ack_word_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Tracking state kept by the testbench.
    logic [SEQ_BITS-1:0] newest_num = '0;
    bit                  any_received = 1'b0;
    bit                  missing_mark [0:(2**SEQ_BITS)-1];

    ack_word_t pending_acks [$];
    int        error_count = 0;
    int        idle_cycles = 0;
    bit        tx_idle_en  = 1'b0;
    bit        rx_idle_en  = 1'b0;
    bit        rx_hold_req = 1'b0;

    reliable_receive_sequence_tracker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Updates the tracking state for one received number and returns its ack word.
    function automatic ack_word_t track_seq(input logic [SEQ_IN_W-1:0] raw);
        logic [SEQ_BITS-1:0] num;
        logic [SEQ_BITS-1:0] ahead;
        logic [SEQ_BITS-1:0] n;
        int                  gap;
        ack_word_t           r;
        num          = raw[SEQ_BITS-1:0];
        ahead        = num - newest_num;
        r.pad        = '0;
        r.ack_id     = raw;
        r.deliver    = 1'b0;
        r.filled_gap = 1'b0;
        if ((ahead != 0 && int'(ahead) <= HALF_WINDOW) || !any_received) begin
            gap = (ahead == 0) ? 0 : int'(ahead) - 1;
            n   = newest_num + 1'b1;
            for (int k = 0; k < gap; k++) begin
                missing_mark[n] = 1'b1;
                n = n + 1'b1;
            end
            // A mark left from an earlier lap is cleared by the new number.
            missing_mark[num] = 1'b0;
            newest_num   = num;
            any_received = 1'b1;
            r.deliver    = 1'b1;
        end else if (missing_mark[num]) begin
            missing_mark[num] = 1'b0;
            r.deliver    = 1'b1;
            r.filled_gap = 1'b1;
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Well-formed traffic: mostly in order, with reordering, duplicates and jumps.
    function automatic logic [SEQ_IN_W-1:0] next_seq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return SEQ_IN_W'(newest_num + $urandom_range(1, 3));
        if (r < 65) return SEQ_IN_W'(newest_num - $urandom_range(0, 40));
        if (r < 78) return SEQ_IN_W'(newest_num - $urandom_range(1, 8));
        if (r < 88) return SEQ_IN_W'(newest_num + $urandom_range(4, 100));
        if (r < 91) return SEQ_IN_W'(newest_num + HALF_WINDOW + $urandom_range(0, 1));
        if (r < 93) return SEQ_IN_W'(newest_num + $urandom_range(30000, HALF_WINDOW));
        return SEQ_IN_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_seq(input logic [SEQ_IN_W-1:0] value);
        int gap;
        gap = tx_idle_en ? rand_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        pending_acks.push_back(track_seq(value));
    endtask

    // Sender goes quiet until every ack word has come back.
    task automatic wait_all_acked();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_acks.size() != 0);
    endtask

    task automatic test_directed();
        logic [SEQ_IN_W-1:0] nums [$];
        // First number zero marks nothing; a repeat of the newest is a duplicate;
        // a jump of exactly half the space is new, one more is old; 7 is new
        // again after the wrap and still carries its mark from the first lap.
        nums = '{16'd0, 16'd0, 16'd100, 16'd100, 16'd50, 16'd50, 16'd99, 16'd1,
                 16'd32868, 16'd7, 16'd7, 16'd32776, 16'd32776, 16'hFFFF, 16'd0,
                 16'd8, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h5556};
        foreach (nums[i]) send_seq(nums[i]);
        wait_all_acked();
    endtask

    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (250) send_seq(next_seq());
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (250) send_seq(next_seq());
    endtask

    task automatic test_reorder_with_gaps();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (400) send_seq(next_seq());
        wait_all_acked();
    endtask

    task automatic test_receiver_holdoff();
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (40) send_seq(SEQ_IN_W'(newest_num + $urandom_range(1, 2)));
        wait_all_acked();
        tx_idle_en = 1'b1;
        repeat (60) send_seq(next_seq());
        wait_all_acked();
    endtask

    task automatic test_random_noise();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (300) send_seq(SEQ_IN_W'($urandom_range(0, 16'hFFFF)));
        wait_all_acked();
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = RX_HOLD_CYCLES;
            end else begin
                stall = rx_idle_en ? rand_gap() : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        ack_word_t want;
        ack_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_acks.size() == 0) begin
                $display("%0t: word expected none got %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_acks.pop_front();
                if (got.ack_id !== want.ack_id) begin
                    $display("%0t: ack_id expected %h got %h", $time, want.ack_id, got.ack_id);
                    error_count++;
                end
                if (got.deliver !== want.deliver) begin
                    $display("%0t: deliver expected %b got %b (ack_id %h)", $time,
                             want.deliver, got.deliver, want.ack_id);
                    error_count++;
                end
                if (got.filled_gap !== want.filled_gap) begin
                    $display("%0t: filled_gap expected %b got %b (ack_id %h)", $time,
                             want.filled_gap, got.filled_gap, want.ack_id);
                    error_count++;
                end
                if (got.pad !== want.pad) begin
                    $display("%0t: pad bits expected %h got %h", $time, want.pad, got.pad);
                    error_count++;
                end
            end
        end
    end

    // The map clear after reset and the longest jump both fit well inside the limit.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_steady_stream();
        test_reorder_with_gaps();
        test_receiver_holdoff();
        test_random_noise();
        wait_all_acked();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
